### hw/rtl/ivmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivmm_pkg : shared types and constants
// Widths, element type codes, register indexes and the result word of the
// integer vector-matrix multiplier.
// ----------------------------------------------------------------------------
package ivmm_pkg;

   // vector store
   localparam int MAX_LEN    = 1024;
   localparam int VEC_ADDR_W = $clog2(MAX_LEN);

   // field widths
   localparam int IDX_W  = 10;
   localparam int LEN_W  = 11;
   localparam int COL_W  = 16;
   localparam int DATA_W = 32;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // result queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_ELEM_TYPE = 2'd0;
   localparam logic [1:0] REG_INNER_LEN = 2'd1;
   localparam logic [1:0] REG_NUM_COLS  = 2'd2;

   typedef enum logic [1:0] {
      ELEM_INT16  = 2'd0,
      ELEM_UINT16 = 2'd1,
      ELEM_INT32  = 2'd2,
      ELEM_UINT32 = 2'd3
   } elem_type_type;

   // one finished column
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [DATA_W-1:0] sum;
      logic              saturated;
      logic              last_column;
   } rsp_word_type;

   // column bookkeeping that travels with each matrix element
   typedef struct packed {
      logic             col_end;
      logic [COL_W-1:0] column;
      logic             last;
   } col_tag_type;

endpackage

### hw/rtl/ivmm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivmm_req_if : request channel
// Valid/ready channel carrying vector loads and matrix elements.
// ----------------------------------------------------------------------------
interface ivmm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [ivmm_pkg::IDX_W-1:0]    vec_index;
   logic [ivmm_pkg::DATA_W-1:0]   value;

   modport source (output valid, output req_type, output vec_index, output value,
                   input ready);
   modport sink   (input valid, input req_type, input vec_index, input value,
                   output ready);
endinterface

### hw/rtl/ivmm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivmm_rsp_if : response channel
// Valid/ready channel carrying one clamped dot product per matrix column.
// ----------------------------------------------------------------------------
interface ivmm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ivmm_pkg::COL_W-1:0]    column;
   logic [ivmm_pkg::DATA_W-1:0]   sum;
   logic                          saturated;
   logic                          last_column;

   modport source (output valid, output column, output sum, output saturated,
                   output last_column, input ready);
   modport sink   (input valid, input column, input sum, input saturated,
                   input last_column, output ready);
endinterface

### hw/rtl/int_vector_matrix_multiply_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_vector_matrix_multiply_sat : integer row vector times matrix, clamped
// Vector entries are loaded into a 1024 x 32 RAM; matrix elements then stream
// column by column and are multiply-accumulated against the stored entries.
// ----------------------------------------------------------------------------
// Takes one word per clock while req.ready is high, loads and matrix elements
// alike. A matrix element reads its vector entry from the store RAM in the
// cycle it is accepted and is multiplied in the next; the product is then
// registered, accumulated, registered again and clamped, and a column's result
// is pushed into the queue ahead of rsp. Results wait in an eight-word queue:
// req.ready drops only while eight results are queued or still in flight, so
// input keeps flowing while results are held up. The store needs no clearing
// after reset; reading an entry that was never loaded gives an undefined sum.
// Registers (APB, 32-bit): 0x0 elem_type, 0x4 inner_len, 0x8 num_cols; write
// them only while the block is idle.
// ----------------------------------------------------------------------------
module int_vector_matrix_multiply_sat (
   input  logic                               clock,
   input  logic                               reset,
   ivmm_req_if.sink                           req,
   ivmm_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ivmm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ivmm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ivmm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import ivmm_pkg::*;

   // --- registers -----------------------------------------------------------
   elem_type_type          elem_type_ff;
   logic [LEN_W-1:0]       inner_len_ff;
   logic [COL_W-1:0]       num_cols_ff;
   logic                   csr_wr;
   logic [1:0]             csr_reg;

   // --- front control -------------------------------------------------------
   logic [LEN_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [RSP_CNT_W-1:0]   reserved_ff, reserved_in;
   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       pos;
   logic [COL_W-1:0]       cols_eff;
   logic                   col_end;
   logic                   col_last;
   logic                   req_acc;
   logic                   mat_acc;
   logic                   ld_acc;
   logic                   rsp_pop;

   // --- pipeline ------------------------------------------------------------
   logic                   s1_valid_ff;
   logic [DATA_W-1:0]      s1_b_ff;
   col_tag_type            s1_tag_ff;
   logic [DATA_W-1:0]      vec_rd_data;
   logic [DATA_W-1:0]      a_ext;
   logic [DATA_W-1:0]      prod;

   logic                   s2_valid_ff;
   logic [DATA_W-1:0]      s2_prod_ff;
   col_tag_type            s2_tag_ff;

   logic [DATA_W-1:0]      acc_ff, acc_in;
   logic [DATA_W-1:0]      acc_sum;

   logic                   s3_valid_ff;
   logic [DATA_W-1:0]      s3_sum_ff;
   logic [COL_W-1:0]       s3_col_ff;
   logic                   s3_last_ff;
   rsp_word_type           push_word;

   // sign/zero extension of one operand by element type
   function automatic logic [DATA_W-1:0] ext_operand(input logic [DATA_W-1:0] raw,
                                                     input elem_type_type et);
      logic [DATA_W-1:0] r;
      case (et)
         ELEM_INT16:  r = {{(DATA_W-16){raw[15]}}, raw[15:0]};
         ELEM_UINT16: r = {{(DATA_W-16){1'b0}}, raw[15:0]};
         default:     r = raw;
      endcase
      return r;
   endfunction

   // --- configuration port --------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_reg    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_type_ff <= ELEM_INT16;
         inner_len_ff <= LEN_W'(1);
         num_cols_ff  <= COL_W'(1);
      end else if (csr_wr) begin
         case (csr_reg)
            REG_ELEM_TYPE: elem_type_ff <= elem_type_type'(csr_pwdata[1:0]);
            REG_INNER_LEN: inner_len_ff <= csr_pwdata[LEN_W-1:0];
            REG_NUM_COLS:  num_cols_ff  <= csr_pwdata[COL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_ELEM_TYPE: csr_prdata = {{(CSR_DATA_W-2){1'b0}}, elem_type_ff};
         REG_INNER_LEN: csr_prdata = CSR_DATA_W'(inner_len_ff);
         REG_NUM_COLS:  csr_prdata = CSR_DATA_W'(num_cols_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // --- accept and column bookkeeping ---------------------------------------
   assign req.ready = (reserved_ff != RSP_CNT_W'(RSP_DEPTH));
   assign req_acc   = req.valid & req.ready;
   assign mat_acc   = req_acc & req.req_type;
   assign ld_acc    = req_acc & ~req.req_type & (32'(req.vec_index) < MAX_LEN);

   always_comb begin
      // effective length: zero acts as one, capped at the store depth
      if (inner_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(inner_len_ff) > MAX_LEN) begin
         len_eff = LEN_W'(MAX_LEN);
      end else begin
         len_eff = inner_len_ff;
      end
      pos      = (row_ff >= len_eff) ? len_eff - LEN_W'(1) : row_ff;
      col_end  = (pos == len_eff - LEN_W'(1));
      cols_eff = (num_cols_ff == '0) ? COL_W'(1) : num_cols_ff;
      col_last = ((COL_W+1)'(col_ff) + (COL_W+1)'(1)) >= (COL_W+1)'(cols_eff);

      row_in = row_ff;
      col_in = col_ff;
      if (mat_acc) begin
         row_in = col_end ? '0 : pos + LEN_W'(1);
         if (col_end) begin
            col_in = col_last ? '0 : col_ff + COL_W'(1);
         end
      end

      // one queue slot held from accept of a column's last element to pop
      reserved_in = reserved_ff;
      if ((mat_acc && col_end) && !rsp_pop) begin
         reserved_in = reserved_ff + RSP_CNT_W'(1);
      end else if (!(mat_acc && col_end) && rsp_pop) begin
         reserved_in = reserved_ff - RSP_CNT_W'(1);
      end
   end

   // --- vector store --------------------------------------------------------
   ivmm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_LEN)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (ld_acc),
      .wr_addr (VEC_ADDR_W'(req.vec_index)),
      .wr_data (req.value),
      .rd_en   (mat_acc),
      .rd_addr (VEC_ADDR_W'(pos)),
      .rd_data (vec_rd_data)
   );

   // --- multiply (store data arrives this cycle) ----------------------------
   assign a_ext = ext_operand(vec_rd_data, elem_type_ff);
   assign prod  = a_ext * s1_b_ff;

   // --- accumulate ----------------------------------------------------------
   assign acc_sum = acc_ff + s2_prod_ff;

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_tag_ff.col_end ? '0 : acc_sum;
      end
   end

   // --- clamp ---------------------------------------------------------------
   always_comb begin
      push_word.column      = s3_col_ff;
      push_word.last_column = s3_last_ff;
      push_word.saturated   = 1'b0;
      push_word.sum         = s3_sum_ff;
      case (elem_type_ff)
         ELEM_INT16: begin
            push_word.sum = {{(DATA_W-16){1'b0}}, s3_sum_ff[15:0]};
            if (!s3_sum_ff[DATA_W-1] && (s3_sum_ff > DATA_W'(32'h0000_7FFF))) begin
               push_word.sum       = DATA_W'(32'h0000_7FFF);
               push_word.saturated = 1'b1;
            end else if (s3_sum_ff[DATA_W-1] &&
                         (s3_sum_ff < DATA_W'(32'hFFFF_8000))) begin
               push_word.sum       = DATA_W'(32'h0000_8000);
               push_word.saturated = 1'b1;
            end
         end
         ELEM_UINT16: begin
            if (s3_sum_ff > DATA_W'(32'h0000_FFFF)) begin
               push_word.sum       = DATA_W'(32'h0000_FFFF);
               push_word.saturated = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // --- control registers ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         reserved_ff <= '0;
         acc_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         reserved_ff <= reserved_in;
         acc_ff      <= acc_in;
         s1_valid_ff <= mat_acc;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff & s2_tag_ff.col_end;
      end
   end

   // --- payload registers ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (mat_acc) begin
         s1_b_ff          <= ext_operand(req.value, elem_type_ff);
         s1_tag_ff.col_end <= col_end;
         s1_tag_ff.column <= col_ff;
         s1_tag_ff.last   <= col_last;
      end
      s2_prod_ff <= prod;
      s2_tag_ff  <= s1_tag_ff;
      s3_sum_ff  <= acc_sum;
      s3_col_ff  <= s2_tag_ff.column;
      s3_last_ff <= s2_tag_ff.last;
   end

   // --- result queue --------------------------------------------------------
   ivmm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_word (push_word),
      .pop       (rsp_pop),
      .rsp       (rsp)
   );

   // --- checks --------------------------------------------------------------
   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("reservation count out of range");

   a_push_reserved: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> reserved_ff != '0)
      else $error("result pushed without a reserved slot");

   a_pop_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_pop |-> reserved_ff != '0)
      else $error("result popped without a reserved slot");

endmodule

### hw/rtl/ivmm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivmm_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ivmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ivmm_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivmm_rsp_fifo : result queue
// Small flop-based queue between the clamp stage and the response channel.
// The caller reserves a slot before an element enters, so push never overflows.
// ----------------------------------------------------------------------------
module ivmm_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ivmm_pkg::rsp_word_type push_word,
   output logic                   pop,
   ivmm_rsp_if.source             rsp
);
   import ivmm_pkg::*;

   rsp_word_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   rsp_word_type           head;

   assign pop  = rsp.valid & rsp.ready;
   assign head = mem_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   // head word onto the channel
   assign rsp.valid       = (count_ff != '0);
   assign rsp.column      = head.column;
   assign rsp.sum         = head.sum;
   assign rsp.saturated   = head.saturated;
   assign rsp.last_column = head.last_column;

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue level out of range");

   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(head))
      else $error("waiting result word changed");

endmodule
